/* src/mmts_pkg.sv */
// Shared types, constants and march element table for the memory march test sequencer.
`default_nettype none
package mmts_pkg;

    localparam int MAX_WORDS_DEF = 67108864;
    localparam int NUM_ELEMENTS  = 20;
    localparam int ELEM_W        = 5;
    localparam int CFG_IDX_W     = 1;
    localparam int COUNT_W       = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT   = 1'b1;

    localparam logic [31:0] PAT_5A5AA5A5 = 32'h5a5aa5a5;
    localparam logic [31:0] PAT_A5A55A5A = 32'ha5a55a5a;
    localparam logic [31:0] PAT_3C3CC3C3 = 32'h3c3cc3c3;
    localparam logic [31:0] PAT_C3C33C3C = 32'hc3c33c3c;
    localparam logic [31:0] PAT_F0F0F0F0 = 32'hf0f0f0f0;
    localparam logic [31:0] PAT_0F0F0F0F = 32'h0f0f0f0f;
    localparam logic [31:0] PAT_00FF00FF = 32'h00ff00ff;
    localparam logic [31:0] PAT_FF00FF00 = 32'hff00ff00;
    localparam logic [31:0] PAT_0000FFFF = 32'h0000ffff;
    localparam logic [31:0] PAT_FFFF0000 = 32'hffff0000;
    localparam logic [31:0] PAT_ONES     = 32'hffffffff;
    localparam logic [31:0] PAT_ZEROS    = 32'h00000000;
    localparam logic [31:0] FILL_PATTERN = PAT_5A5AA5A5;

    typedef struct packed {
        logic [31:0] rd;
        logic [31:0] wr;
        logic        up;
    } t_elem;

    typedef struct packed {
        logic [31:0] mem_address;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] write_data;
        logic        busy_res;
        logic        done_res;
        logic        passed;
        logic [31:0] fail_address;
        logic [31:0] fail_expected;
        logic [31:0] fail_actual;
    } t_result;

    function automatic t_elem elem_of(input logic [ELEM_W-1:0] idx);
        t_elem e;
        case (idx)
            5'd0:    e = '{rd: PAT_5A5AA5A5, wr: PAT_A5A55A5A, up: 1'b1};
            5'd1:    e = '{rd: PAT_A5A55A5A, wr: PAT_5A5AA5A5, up: 1'b1};
            5'd2:    e = '{rd: PAT_5A5AA5A5, wr: PAT_A5A55A5A, up: 1'b0};
            5'd3:    e = '{rd: PAT_A5A55A5A, wr: PAT_5A5AA5A5, up: 1'b0};
            5'd4:    e = '{rd: PAT_5A5AA5A5, wr: PAT_3C3CC3C3, up: 1'b1};
            5'd5:    e = '{rd: PAT_3C3CC3C3, wr: PAT_C3C33C3C, up: 1'b0};
            5'd6:    e = '{rd: PAT_C3C33C3C, wr: PAT_3C3CC3C3, up: 1'b1};
            5'd7:    e = '{rd: PAT_3C3CC3C3, wr: PAT_F0F0F0F0, up: 1'b0};
            5'd8:    e = '{rd: PAT_F0F0F0F0, wr: PAT_0F0F0F0F, up: 1'b1};
            5'd9:    e = '{rd: PAT_0F0F0F0F, wr: PAT_F0F0F0F0, up: 1'b0};
            5'd10:   e = '{rd: PAT_F0F0F0F0, wr: PAT_00FF00FF, up: 1'b1};
            5'd11:   e = '{rd: PAT_00FF00FF, wr: PAT_FF00FF00, up: 1'b0};
            5'd12:   e = '{rd: PAT_FF00FF00, wr: PAT_00FF00FF, up: 1'b1};
            5'd13:   e = '{rd: PAT_00FF00FF, wr: PAT_0000FFFF, up: 1'b0};
            5'd14:   e = '{rd: PAT_0000FFFF, wr: PAT_FFFF0000, up: 1'b1};
            5'd15:   e = '{rd: PAT_FFFF0000, wr: PAT_0000FFFF, up: 1'b0};
            5'd16:   e = '{rd: PAT_0000FFFF, wr: PAT_ONES,     up: 1'b1};
            5'd17:   e = '{rd: PAT_ONES,     wr: PAT_ZEROS,    up: 1'b0};
            5'd18:   e = '{rd: PAT_ZEROS,    wr: PAT_ONES,     up: 1'b1};
            5'd19:   e = '{rd: PAT_ONES,     wr: PAT_ZEROS,    up: 1'b0};
            default: e = '{rd: PAT_ZEROS,    wr: PAT_ZEROS,    up: 1'b1};
        endcase
        return e;
    endfunction

endpackage
`default_nettype wire

/* src/mmts_ifs.sv */
// Valid/ready channel interfaces for input words, result words and configuration writes.
`default_nettype none
interface mmts_in_if;
    logic        valid;
    logic        ready;
    logic        start_test;
    logic [31:0] read_data;

    modport source (output valid, output start_test, output read_data, input ready);
    modport sink   (input valid, input start_test, input read_data, output ready);
endinterface

interface mmts_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mem_address;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] write_data;
    logic        busy_res;
    logic        done_res;
    logic        passed;
    logic [31:0] fail_address;
    logic [31:0] fail_expected;
    logic [31:0] fail_actual;

    modport source (
        output valid, output mem_address, output mem_read, output mem_write,
        output write_data, output busy_res, output done_res, output passed,
        output fail_address, output fail_expected, output fail_actual,
        input ready
    );
    modport sink (
        input valid, input mem_address, input mem_read, input mem_write,
        input write_data, input busy_res, input done_res, input passed,
        input fail_address, input fail_expected, input fail_actual,
        output ready
    );
endinterface

interface mmts_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mmts_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/memory_march_test_sequencer_top.sv */
// Top level of the memory march test sequencer: channels, config registers, stage registers.
//
// Channels: i_in carries one word per memory tick (start_test, read_data for the read
// issued on the previous tick); o_out returns one result word per input word: the
// memory command of that tick plus run status and failure details. i_cfg writes
// base_address (index 0) and word_count (index 1); it is always ready; the user must write
// it only while no run is active, as the block itself does not enforce this.
// Registers: an accepted input word is held in the input register, and the result word
// computed from it is held in the result register. Throughput: one word per cycle while
// o_out.ready does not stall the output; the whole command decision is one pass of logic
// between the two registers, bounded by the 32-bit address add and word-index compare.
// A run of n words takes n + n + n + 20 * 2n input words, plus one for a pass result.
// Reset: synchronous, active low; clears the run state (idle, not done) and sets
// both config registers to zero.
// Stall: while o_out.ready is low the result word holds; one further input word is
// taken into the input register, then i_in.ready drops until the result is taken.
`default_nettype none
module memory_march_test_sequencer_top #(
    parameter int MAX_WORDS = mmts_pkg::MAX_WORDS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mmts_in_if.sink    i_in,
    mmts_out_if.source o_out,
    mmts_cfg_if.sink   i_cfg
);

    logic [31:0]                  r_base;
    logic [mmts_pkg::COUNT_W-1:0] r_count;
    logic                         r_in_valid;
    logic                         r_in_start;
    logic [31:0]                  r_in_rd;
    logic                         r_out_valid;
    mmts_pkg::t_result            r_res;
    mmts_pkg::t_result            seq_res;
    logic                         out_free;
    logic                         advance;

    assign out_free    = !r_out_valid || o_out.ready;
    assign advance     = r_in_valid && out_free;
    assign i_in.ready  = !r_in_valid || out_free;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                mmts_pkg::CFG_BASE_ADDRESS: r_base  <= i_cfg.data;
                mmts_pkg::CFG_WORD_COUNT:   r_count <= i_cfg.data[mmts_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_start <= i_in.start_test;
            r_in_rd    <= i_in.read_data;
        end
    end

    mmts_seq #(
        .MAX_WORDS (MAX_WORDS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_start (r_in_start),
        .i_rd    (r_in_rd),
        .i_base  (r_base),
        .i_count (r_count),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= seq_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.mem_address   = r_res.mem_address;
    assign o_out.mem_read      = r_res.mem_read;
    assign o_out.mem_write     = r_res.mem_write;
    assign o_out.write_data    = r_res.write_data;
    assign o_out.busy_res      = r_res.busy_res;
    assign o_out.done_res      = r_res.done_res;
    assign o_out.passed        = r_res.passed;
    assign o_out.fail_address  = r_res.fail_address;
    assign o_out.fail_expected = r_res.fail_expected;
    assign o_out.fail_actual   = r_res.fail_actual;

endmodule
`default_nettype wire

/* src/mmts_seq.sv */
// Run state registers and combinational next-command logic of the march test sequencer.
`default_nettype none
module mmts_seq #(
    parameter int MAX_WORDS = mmts_pkg::MAX_WORDS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_start,
    input  wire logic [31:0]                 i_rd,
    input  wire logic [31:0]                 i_base,
    input  wire logic [mmts_pkg::COUNT_W-1:0] i_count,
    output mmts_pkg::t_result                o_res
);

    localparam int IDX_W = $clog2(MAX_WORDS + 1);
    localparam int EW    = mmts_pkg::ELEM_W;
    localparam logic [EW-1:0] LAST_ELEM = EW'(mmts_pkg::NUM_ELEMENTS);

    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_FILL_ADDR   = 6'b000010,
        PH_VERIFY_ADDR = 6'b000100,
        PH_FILL_PAT    = 6'b001000,
        PH_MARCH       = 6'b010000,
        PH_DONE        = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {WD_ADDR, WD_FILL, WD_ELEM} t_wdsel;
    typedef enum logic [1:0] {EV_KEEP, EV_ADDR, EV_CUR, EV_ENT} t_evsel;
    typedef enum logic [1:0] {END_NONE, END_PASS, END_FAIL_EV, END_FAIL_ADDR} t_end;

    t_phase          r_phase, n_phase, s_phase;
    logic [EW-1:0]   r_ei, n_ei, s_ei;
    logic [IDX_W-1:0] r_wi, n_wi, s_wi;
    logic            r_cp, n_cp, s_cp;
    logic [31:0]     r_ev, n_ev, s_ev;
    logic            r_fin, n_fin, s_fin;
    logic            r_pass, n_pass, s_pass;
    logic [31:0]     r_fa, n_fa, s_fa;
    logic [31:0]     r_fact, n_fact, s_fact;

    logic [31:0]     cnt32, max32, n32, wi32, wi_inc32;
    logic            wi_lt, n_nz, mismatch, startable;
    logic [EW-1:0]   ent_idx;
    mmts_pkg::t_elem e_cur, e_ent;
    logic            ent_ok;
    logic [31:0]     idx_cur, idx_ent;

    logic            c_rd, c_wr;
    logic [31:0]     c_idx, addr, wdata;
    t_wdsel          wd_sel;
    t_evsel          ev_sel;
    t_end            end_kind;
    logic            failed;

    assign cnt32    = 32'(i_count);
    assign max32    = 32'(MAX_WORDS);
    assign n32      = (cnt32 > max32) ? max32 : cnt32;
    assign n_nz     = (n32 != 32'd0);

    always_comb begin
        case (r_phase)
            PH_FILL_ADDR, PH_VERIFY_ADDR, PH_FILL_PAT, PH_MARCH: startable = 1'b0;
            default: startable = 1'b1;
        endcase
        s_phase = r_phase;
        s_ei    = r_ei;
        s_wi    = r_wi;
        s_cp    = r_cp;
        s_ev    = r_ev;
        s_fin   = r_fin;
        s_pass  = r_pass;
        s_fa    = r_fa;
        s_fact  = r_fact;
        if (i_start && startable) begin
            s_phase = PH_FILL_ADDR;
            s_ei    = '0;
            s_wi    = '0;
            s_cp    = 1'b0;
            s_ev    = '0;
            s_fin   = 1'b0;
            s_pass  = 1'b0;
            s_fa    = '0;
            s_fact  = '0;
        end
    end

    assign wi32     = 32'(s_wi);
    assign wi_inc32 = wi32 + 32'd1;
    assign wi_lt    = (wi32 < n32);
    assign mismatch = s_cp && (i_rd != s_ev);
    assign ent_idx  = (s_phase == PH_MARCH) ? s_ei + EW'(1) : '0;
    assign e_cur    = mmts_pkg::elem_of(s_ei);
    assign e_ent    = mmts_pkg::elem_of(ent_idx);
    assign ent_ok   = (ent_idx < LAST_ELEM) && n_nz;
    assign idx_cur  = e_cur.up ? wi32 : (n32 - 32'd1 - wi32);
    assign idx_ent  = e_ent.up ? 32'd0 : (n32 - 32'd1);

    // command and next control state
    always_comb begin
        n_phase  = s_phase;
        n_ei     = s_ei;
        n_wi     = s_wi;
        n_cp     = s_cp;
        c_rd     = 1'b0;
        c_wr     = 1'b0;
        c_idx    = '0;
        wd_sel   = WD_ADDR;
        ev_sel   = EV_KEEP;
        end_kind = END_NONE;
        case (s_phase)
            PH_FILL_ADDR: begin
                if (wi_lt) begin
                    c_wr  = 1'b1;
                    c_idx = wi32;
                    n_wi  = IDX_W'(wi_inc32);
                end else if (n_nz) begin
                    c_rd    = 1'b1;
                    ev_sel  = EV_ADDR;
                    n_cp    = 1'b1;
                    n_wi    = IDX_W'(1);
                    n_phase = PH_VERIFY_ADDR;
                end else begin
                    end_kind = END_PASS;
                end
            end
            PH_VERIFY_ADDR: begin
                if (mismatch) begin
                    end_kind = END_FAIL_EV;
                end else if (wi_lt) begin
                    c_rd   = 1'b1;
                    c_idx  = wi32;
                    ev_sel = EV_ADDR;
                    n_cp   = 1'b1;
                    n_wi   = IDX_W'(wi_inc32);
                end else if (n_nz) begin
                    c_wr    = 1'b1;
                    wd_sel  = WD_FILL;
                    n_cp    = 1'b0;
                    n_wi    = IDX_W'(1);
                    n_phase = PH_FILL_PAT;
                end else begin
                    end_kind = END_PASS;
                end
            end
            PH_FILL_PAT, PH_MARCH: begin
                if (s_phase == PH_FILL_PAT && wi_lt) begin
                    c_wr   = 1'b1;
                    c_idx  = wi32;
                    wd_sel = WD_FILL;
                    n_wi   = IDX_W'(wi_inc32);
                end else if (s_phase == PH_MARCH && s_ei >= LAST_ELEM) begin
                    end_kind = END_PASS;
                end else if (s_phase == PH_MARCH && s_cp) begin
                    c_idx = idx_cur;
                    if (mismatch) begin
                        end_kind = END_FAIL_ADDR;
                    end else begin
                        c_wr   = 1'b1;
                        wd_sel = WD_ELEM;
                        n_cp   = 1'b0;
                        n_wi   = IDX_W'(wi_inc32);
                    end
                end else if (s_phase == PH_MARCH && wi_lt) begin
                    c_rd   = 1'b1;
                    c_idx  = idx_cur;
                    ev_sel = EV_CUR;
                    n_cp   = 1'b1;
                end else if (ent_ok) begin
                    // next element starts at once
                    c_rd    = 1'b1;
                    c_idx   = idx_ent;
                    ev_sel  = EV_ENT;
                    n_cp    = 1'b1;
                    n_ei    = ent_idx;
                    n_wi    = '0;
                    n_phase = PH_MARCH;
                end else begin
                    end_kind = END_PASS;
                end
            end
            default: begin
                n_phase = (s_phase == PH_DONE) ? PH_DONE : PH_IDLE;
            end
        endcase
    end

    assign addr = {i_base[31:2], 2'b00} + {c_idx[29:0], 2'b00};

    always_comb begin
        case (wd_sel)
            WD_FILL: wdata = mmts_pkg::FILL_PATTERN;
            WD_ELEM: wdata = e_cur.wr;
            default: wdata = addr;
        endcase
        case (ev_sel)
            EV_ADDR: n_ev = addr;
            EV_CUR:  n_ev = e_cur.rd;
            EV_ENT:  n_ev = e_ent.rd;
            default: n_ev = s_ev;
        endcase
        n_fin  = s_fin;
        n_pass = s_pass;
        n_fa   = s_fa;
        n_fact = s_fact;
        case (end_kind)
            END_PASS: begin
                n_fin  = 1'b1;
                n_pass = 1'b1;
            end
            END_FAIL_EV: begin
                n_fin  = 1'b1;
                n_pass = 1'b0;
                n_fa   = s_ev;
                n_fact = i_rd;
            end
            END_FAIL_ADDR: begin
                n_fin  = 1'b1;
                n_pass = 1'b0;
                n_fa   = addr;
                n_fact = i_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ei    <= '0;
            r_wi    <= '0;
            r_cp    <= 1'b0;
            r_ev    <= '0;
            r_fin   <= 1'b0;
            r_pass  <= 1'b0;
            r_fa    <= '0;
            r_fact  <= '0;
        end else if (i_en) begin
            r_phase <= (end_kind != END_NONE) ? PH_DONE : n_phase;
            r_ei    <= n_ei;
            r_wi    <= n_wi;
            r_cp    <= (end_kind != END_NONE) ? 1'b0 : n_cp;
            r_ev    <= n_ev;
            r_fin   <= n_fin;
            r_pass  <= n_pass;
            r_fa    <= n_fa;
            r_fact  <= n_fact;
        end
    end

    assign failed = n_fin && !n_pass;

    always_comb begin
        o_res.mem_address   = (c_rd || c_wr) ? addr : '0;
        o_res.mem_read      = c_rd;
        o_res.mem_write     = c_wr;
        o_res.write_data    = c_wr ? wdata : '0;
        o_res.busy_res      = (end_kind == END_NONE) &&
                              (n_phase != PH_IDLE) && (n_phase != PH_DONE);
        o_res.done_res      = n_fin;
        o_res.passed        = n_fin && n_pass;
        o_res.fail_address  = failed ? n_fa : '0;
        o_res.fail_expected = failed ? n_ev : '0;
        o_res.fail_actual   = failed ? n_fact : '0;
    end

endmodule
`default_nettype wire

/* test/memory_march_test_sequencer_top_test.sv */
// Self-checking testbench for the memory march test sequencer top level.
`timescale 1ns / 100ps
module memory_march_test_sequencer_top_test;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 10;
    localparam int          TOTAL_WORDS    = 1750;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int unsigned WORD_LIMIT     = mmts_pkg::MAX_WORDS_DEF;
    localparam int          MARCH_LEN      = 20;
    localparam logic [31:0] SOLID_FILL     = 32'h5a5aa5a5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR_FILL,
        ST_ADDR_CHECK,
        ST_PAT_FILL,
        ST_MARCH,
        ST_DONE
    } t_seq_phase;

    typedef struct packed {
        logic        start;
        logic [31:0] data;
    } t_word;

    typedef struct packed {
        logic [31:0] base;
        logic [26:0] count;
    } t_cfg;

    typedef struct packed {
        logic [31:0] rd_pat;
        logic [31:0] wr_pat;
        logic        ascend;
    } t_march_elem;

    typedef struct packed {
        t_seq_phase  phase;
        logic [4:0]  elem;
        logic [26:0] widx;
        logic        pending;
        logic [31:0] exp_val;
        logic        finished;
        logic        ok;
        logic [31:0] fail_addr;
        logic [31:0] fail_act;
    } t_seq_state;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mmts_in_if  in_if ();
    mmts_out_if out_if ();
    mmts_cfg_if cfg_if ();

    memory_march_test_sequencer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_word             word_queue[$];
    mmts_pkg::t_result result_queue[$];
    t_seq_state        gen_state;
    t_seq_state        chk_state;
    t_cfg              cfg_mirror;
    t_word             sent_word;
    t_word             next_word;
    mmts_pkg::t_result step_result;
    mmts_pkg::t_result want;
    logic [31:0]       mem_image[logic [31:0]];
    logic              gen_prev_rd;
    logic [31:0]       gen_prev_addr;

    int unsigned source_idle_pct = 0;
    int unsigned sink_idle_pct   = 0;
    int unsigned words_queued    = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned idle_cycles     = 0;
    int unsigned runs_done       = 0;
    int unsigned runs_failed     = 0;
    int unsigned settings        = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_march_elem march_elem(input logic [4:0] k);
        t_march_elem e;
        case (k)
            5'd0:    e = '{32'h5a5aa5a5, 32'ha5a55a5a, 1'b1};
            5'd1:    e = '{32'ha5a55a5a, 32'h5a5aa5a5, 1'b1};
            5'd2:    e = '{32'h5a5aa5a5, 32'ha5a55a5a, 1'b0};
            5'd3:    e = '{32'ha5a55a5a, 32'h5a5aa5a5, 1'b0};
            5'd4:    e = '{32'h5a5aa5a5, 32'h3c3cc3c3, 1'b1};
            5'd5:    e = '{32'h3c3cc3c3, 32'hc3c33c3c, 1'b0};
            5'd6:    e = '{32'hc3c33c3c, 32'h3c3cc3c3, 1'b1};
            5'd7:    e = '{32'h3c3cc3c3, 32'hf0f0f0f0, 1'b0};
            5'd8:    e = '{32'hf0f0f0f0, 32'h0f0f0f0f, 1'b1};
            5'd9:    e = '{32'h0f0f0f0f, 32'hf0f0f0f0, 1'b0};
            5'd10:   e = '{32'hf0f0f0f0, 32'h00ff00ff, 1'b1};
            5'd11:   e = '{32'h00ff00ff, 32'hff00ff00, 1'b0};
            5'd12:   e = '{32'hff00ff00, 32'h00ff00ff, 1'b1};
            5'd13:   e = '{32'h00ff00ff, 32'h0000ffff, 1'b0};
            5'd14:   e = '{32'h0000ffff, 32'hffff0000, 1'b1};
            5'd15:   e = '{32'hffff0000, 32'h0000ffff, 1'b0};
            5'd16:   e = '{32'h0000ffff, 32'hffffffff, 1'b1};
            5'd17:   e = '{32'hffffffff, 32'h00000000, 1'b0};
            5'd18:   e = '{32'h00000000, 32'hffffffff, 1'b1};
            default: e = '{32'hffffffff, 32'h00000000, 1'b0};
        endcase
        return e;
    endfunction

    function automatic t_seq_state idle_state();
        t_seq_state s;
        s.phase     = ST_IDLE;
        s.elem      = '0;
        s.widx      = '0;
        s.pending   = 1'b0;
        s.exp_val   = '0;
        s.finished  = 1'b0;
        s.ok        = 1'b0;
        s.fail_addr = '0;
        s.fail_act  = '0;
        return s;
    endfunction

    function automatic logic [31:0] word_addr(input t_cfg c, input logic [31:0] idx);
        return (c.base & 32'hffff_fffc) + (idx << 2);
    endfunction

    task automatic finish_run(inout t_seq_state s, input logic ok, input logic [31:0] addr,
                              input logic [31:0] actual);
        s.finished = 1'b1;
        s.ok       = ok;
        if (!ok) begin
            s.fail_addr = addr;
            s.fail_act  = actual;
        end
        s.pending = 1'b0;
        s.phase   = ST_DONE;
    endtask

    // One tick of the sequencer: the command it issues and the status after the tick.
    task automatic seq_step(inout t_seq_state s, input t_cfg c, input t_word w,
                            output mmts_pkg::t_result r);
        logic [31:0] n;
        logic [31:0] cmd_addr;
        logic [31:0] cmd_data;
        logic [31:0] idx;
        logic        cmd_rd;
        logic        cmd_wr;
        logic        halt;
        logic        failed;
        t_march_elem e;
        int          iter;
        n        = (c.count > WORD_LIMIT) ? WORD_LIMIT : {5'd0, c.count};
        cmd_addr = '0;
        cmd_data = '0;
        cmd_rd   = 1'b0;
        cmd_wr   = 1'b0;
        halt     = 1'b0;
        if (w.start && (s.phase == ST_IDLE || s.phase == ST_DONE)) begin
            s       = idle_state();
            s.phase = ST_ADDR_FILL;
        end
        for (iter = 0; iter < 64 && !cmd_rd && !cmd_wr && !halt; iter++) begin
            case (s.phase)
                ST_ADDR_FILL: begin
                    if (s.widx < n) begin
                        cmd_addr = word_addr(c, {5'd0, s.widx});
                        cmd_data = cmd_addr;
                        cmd_wr   = 1'b1;
                        s.widx   = s.widx + 1'b1;
                    end else begin
                        s.phase = ST_ADDR_CHECK;
                        s.widx  = '0;
                    end
                end
                ST_ADDR_CHECK: begin
                    if (s.pending) begin
                        s.pending = 1'b0;
                        if (w.data != s.exp_val) begin
                            finish_run(s, 1'b0, s.exp_val, w.data);
                            halt = 1'b1;
                        end
                    end
                    if (!halt) begin
                        if (s.widx < n) begin
                            cmd_addr  = word_addr(c, {5'd0, s.widx});
                            cmd_rd    = 1'b1;
                            s.exp_val = cmd_addr;
                            s.pending = 1'b1;
                            s.widx    = s.widx + 1'b1;
                        end else begin
                            s.phase = ST_PAT_FILL;
                            s.widx  = '0;
                        end
                    end
                end
                ST_PAT_FILL: begin
                    if (s.widx < n) begin
                        cmd_addr = word_addr(c, {5'd0, s.widx});
                        cmd_data = SOLID_FILL;
                        cmd_wr   = 1'b1;
                        s.widx   = s.widx + 1'b1;
                    end else begin
                        s.phase = ST_MARCH;
                        s.elem  = '0;
                        s.widx  = '0;
                    end
                end
                ST_MARCH: begin
                    if (s.elem >= MARCH_LEN) begin
                        finish_run(s, 1'b1, '0, '0);
                        halt = 1'b1;
                    end else begin
                        e   = march_elem(s.elem);
                        idx = e.ascend ? {5'd0, s.widx} : n - 32'd1 - {5'd0, s.widx};
                        if (s.pending) begin
                            s.pending = 1'b0;
                            if (w.data != s.exp_val) begin
                                finish_run(s, 1'b0, word_addr(c, idx), w.data);
                                halt = 1'b1;
                            end else begin
                                cmd_addr = word_addr(c, idx);
                                cmd_data = e.wr_pat;
                                cmd_wr   = 1'b1;
                                s.widx   = s.widx + 1'b1;
                            end
                        end else if (s.widx < n) begin
                            cmd_addr  = word_addr(c, idx);
                            cmd_rd    = 1'b1;
                            s.exp_val = e.rd_pat;
                            s.pending = 1'b1;
                        end else begin
                            s.elem = s.elem + 1'b1;
                            s.widx = '0;
                        end
                    end
                end
                default: halt = 1'b1;
            endcase
        end
        failed          = s.finished && !s.ok;
        r.mem_address   = cmd_addr;
        r.mem_read      = cmd_rd;
        r.mem_write     = cmd_wr;
        r.write_data    = cmd_wr ? cmd_data : '0;
        r.busy_res      = (s.phase != ST_IDLE && s.phase != ST_DONE);
        r.done_res      = s.finished;
        r.passed        = s.finished && s.ok;
        r.fail_address  = failed ? s.fail_addr : '0;
        r.fail_expected = failed ? s.exp_val : '0;
        r.fail_actual   = failed ? s.fail_act : '0;
    endtask

    // Read data mirrors a memory holding what the sequencer wrote; corrupt flips one bit.
    task automatic queue_word(input logic start, input logic corrupt, input logic [31:0] fill);
        t_word             w;
        mmts_pkg::t_result r;
        w.start = start;
        if (gen_prev_rd) begin
            w.data = mem_image.exists(gen_prev_addr) ? mem_image[gen_prev_addr] : $urandom;
            if (corrupt) begin
                w.data = w.data ^ (32'h1 << $urandom_range(0, 31));
            end
        end else begin
            w.data = fill;
        end
        seq_step(gen_state, cfg_mirror, w, r);
        if (r.mem_write) begin
            mem_image[r.mem_address] = r.write_data;
        end
        gen_prev_rd   = r.mem_read;
        gen_prev_addr = r.mem_address;
        word_queue.push_back(w);
        words_queued++;
    endtask

    task automatic queue_run();
        queue_word(1'b1, 1'b0, $urandom);
        while (gen_state.phase != ST_DONE) begin
            queue_word($urandom_range(0, 39) == 0, $urandom_range(0, 149) == 0, $urandom);
        end
        runs_done++;
        if (!gen_state.ok) begin
            runs_failed++;
        end
    endtask

    task automatic drain();
        while (word_queue.size() != 0 || result_queue.size() != 0 || in_if.valid) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mmts_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            mmts_pkg::CFG_BASE_ADDRESS: cfg_mirror.base = value;
            mmts_pkg::CFG_WORD_COUNT:   cfg_mirror.count = value[26:0];
            default:                    ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_idling();
        case (words_queued * 3 / TOTAL_WORDS)
            0: begin
                source_idle_pct = 7;
                sink_idle_pct   = 61;
            end
            1: begin
                source_idle_pct = 61;
                sink_idle_pct   = 7;
            end
            default: begin
                source_idle_pct = 0;
                sink_idle_pct   = 0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result word %0d, %s: expected %h, got %h",
                         results_checked, name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                seq_step(chk_state, cfg_mirror, sent_word, step_result);
                result_queue.push_back(step_result);
            end
            if (!in_if.valid || in_if.ready) begin
                if (word_queue.size() != 0 && $urandom_range(0, 99) >= source_idle_pct) begin
                    next_word = word_queue.pop_front();
                    sent_word        <= next_word;
                    in_if.start_test <= next_word.start;
                    in_if.read_data  <= next_word.data;
                    in_if.valid      <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (result_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result word %0d arrived with nothing expected", results_checked);
                    end
                end else begin
                    want = result_queue.pop_front();
                    check_field("mem_address", want.mem_address, out_if.mem_address);
                    check_field("mem_read", 32'(want.mem_read), 32'(out_if.mem_read));
                    check_field("mem_write", 32'(want.mem_write), 32'(out_if.mem_write));
                    check_field("write_data", want.write_data, out_if.write_data);
                    check_field("busy_res", 32'(want.busy_res), 32'(out_if.busy_res));
                    check_field("done_res", 32'(want.done_res), 32'(out_if.done_res));
                    check_field("passed", 32'(want.passed), 32'(out_if.passed));
                    check_field("fail_address", want.fail_address, out_if.fail_address);
                    check_field("fail_expected", want.fail_expected, out_if.fail_expected);
                    check_field("fail_actual", want.fail_actual, out_if.fail_actual);
                end
                results_checked++;
            end
            out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("memory_march_test_sequencer_top test failed");
        $finish;
    end

    initial begin
        logic [31:0] base_val;
        logic [31:0] cfg_word;
        logic [26:0] count_val;
        int          pick;
        int unsigned phase_end;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = mmts_pkg::CFG_BASE_ADDRESS;
        cfg_if.data      = '0;
        gen_state        = idle_state();
        chk_state        = idle_state();
        cfg_mirror       = '0;
        gen_prev_rd      = 1'b0;
        gen_prev_addr    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_idling();

        // zero words: a start passes at once, and a start from done restarts
        write_reg(mmts_pkg::CFG_BASE_ADDRESS, 32'h0);
        write_reg(mmts_pkg::CFG_WORD_COUNT, 32'h0);
        settings++;
        queue_word(1'b0, 1'b0, 32'h0000_0000);
        queue_word(1'b0, 1'b0, 32'hffff_ffff);
        queue_word(1'b1, 1'b0, $urandom);
        queue_word(1'b1, 1'b0, $urandom);
        queue_word(1'b0, 1'b0, $urandom);

        // unaligned base at the top of the address space wraps; start while busy;
        // mismatch in the address check
        drain();
        write_reg(mmts_pkg::CFG_BASE_ADDRESS, 32'hffff_ffff);
        write_reg(mmts_pkg::CFG_WORD_COUNT, 32'h2);
        settings++;
        queue_word(1'b1, 1'b0, $urandom);
        queue_word(1'b0, 1'b0, $urandom);
        queue_word(1'b0, 1'b0, $urandom);
        queue_word(1'b1, 1'b0, $urandom);
        queue_word(1'b0, 1'b1, $urandom);
        queue_word(1'b0, 1'b0, $urandom);

        // mismatch in the first march element
        drain();
        write_reg(mmts_pkg::CFG_BASE_ADDRESS, 32'h0000_0008);
        write_reg(mmts_pkg::CFG_WORD_COUNT, 32'h1);
        settings++;
        queue_word(1'b1, 1'b0, $urandom);
        queue_word(1'b0, 1'b0, $urandom);
        queue_word(1'b0, 1'b0, $urandom);
        queue_word(1'b0, 1'b0, $urandom);
        queue_word(1'b0, 1'b1, $urandom);

        while (words_queued < TOTAL_WORDS) begin
            drain();
            set_idling();
            case ($urandom_range(0, 3))
                0:       base_val = 32'h0;
                1:       base_val = 32'hffff_fff0 | $urandom_range(0, 15);
                2:       base_val = 32'hffff_ffff;
                default: base_val = $urandom;
            endcase
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                count_val = '0;
            end else if (pick <= 7) begin
                count_val = 27'($urandom_range(1, 3));
            end else if (pick == 8) begin
                count_val = 27'($urandom_range(4, 6));
            end else if (pick == 9) begin
                count_val = 27'd8;
            end else if (pick == 10) begin
                count_val = 27'(WORD_LIMIT);
            end else begin
                count_val = '1;
            end
            cfg_word       = $urandom;
            cfg_word[26:0] = count_val;
            write_reg(mmts_pkg::CFG_BASE_ADDRESS, base_val);
            write_reg(mmts_pkg::CFG_WORD_COUNT, cfg_word);
            settings++;
            if (pick >= 10) begin
                // too long to run; only the held status is seen
                repeat ($urandom_range(3, 8)) queue_word(1'b0, 1'b0, $urandom);
            end else begin
                phase_end = words_queued + 100;
                while (words_queued < phase_end) begin
                    repeat ($urandom_range(0, 2)) queue_word(1'b0, 1'b0, $urandom);
                    queue_run();
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (result_queue.size() != 0) begin
            mismatch_count++;
            $display("%0d result words never arrived", result_queue.size());
        end
        $display("%0d input words under %0d register settings; %0d random runs, %0d on a mismatch",
                 words_queued, settings, runs_done, runs_failed);
        $display("%0d result words checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("memory_march_test_sequencer_top test passed");
        end else begin
            $display("memory_march_test_sequencer_top test failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/mmts_pkg.sv
src/mmts_ifs.sv
src/mmts_seq.sv
src/memory_march_test_sequencer_top.sv
test/memory_march_test_sequencer_top_test.sv
